// ===== sv/dls_pkg.sv =====
// Package: shared types and constants for the dense layer sigmoid unit.
`default_nettype none
package dls_pkg;
  localparam int unsigned KindW  = 2;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned ValW   = 16;
  localparam int unsigned ActW   = 13;
  localparam int unsigned CntW   = 5;
  localparam int unsigned AccW   = 40;
  localparam int unsigned ResultLimit = 16;

  typedef enum logic [KindW-1:0] {
    KIND_WEIGHT = 2'd0,
    KIND_BIAS   = 2'd1,
    KIND_ACT    = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  localparam logic CFG_IN_COUNT  = 1'b0;
  localparam logic CFG_OUT_COUNT = 1'b1;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [IdxW-1:0]  src_index;
    logic [IdxW-1:0]  dst_index;
    logic [ValW-1:0]  value;
    logic             final_element;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0] out_index;
    logic [ActW-1:0] activation;
    logic            run_end;
  } out_item_t;

  typedef struct packed {
    logic           wr;
    logic           cfg_in;
    logic [CntW-1:0] data;
  } cfg_wr_t;

  typedef logic [255:0][ActW-1:0] sig_table_t;

  // Restoring long division, only used while building constant tables.
  function automatic logic [63:0] const_div(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid table, entry j samples sigmoid at (j - 128) / 16, Q1.12.
  function automatic sig_table_t build_sig_table();
    sig_table_t tbl;
    logic [63:0] p;
    logic [63:0] den;
    tbl = '0;
    p = 64'd1073741824;
    for (int k = 0; k <= 128; k++) begin
      den = 64'd1073741824 + p;
      if (k < 128)
        tbl[128 + k] = ActW'(const_div((64'd4096 << 30) + (den >> 1), den));
      if (k >= 1)
        tbl[128 - k] = ActW'(const_div(64'd4096 * p + (den >> 1), den));
      p = (p * 64'd1008687091 + (64'd1 << 29)) >> 30;
    end
    return tbl;
  endfunction

  localparam sig_table_t SigTable = build_sig_table();
endpackage
`default_nettype wire

// ===== sv/dls_if.sv =====
// Interfaces: valid/ready item channel and configuration write channel.
`default_nettype none
interface dls_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dls_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [4:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ===== sv/dense_layer_sigmoid_forward_unit.sv =====
// Top level: dense layer with sigmoid output, front queue plus MAC back end.
// Load items pass through a 4-entry queue (1 item/cycle while it has room).
// A final activation starts a run: each output is computed in turn on
// the single shared multiplier-accumulator, results leave in output order.
// The queue is emptied only while no run is busy.
// Reset: asynchronous active low; counts return to 16, stores undefined.
`default_nettype none
module dense_layer_sigmoid_forward_unit #(
  parameter int unsigned MAX_IN  = 16,
  parameter int unsigned MAX_OUT = 16
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  dls_stream_if.sink   in_if,
  dls_stream_if.source out_if,
  dls_cfg_if.sink      cfg_if
);
  import dls_pkg::*;

  in_item_t q_data;
  logic     q_valid, q_pop;
  cfg_wr_t  cfg;

  assign cfg_if.ready = 1'b1;
  assign cfg.wr     = cfg_if.valid;
  assign cfg.cfg_in = (cfg_if.index == CFG_IN_COUNT);
  assign cfg.data   = cfg_if.wdata;

  dls_front #(.Depth(4)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_if.data),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  dls_back #(.MaxIn(MAX_IN), .MaxOut(MAX_OUT)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_data_o(out_if.data)
  );
endmodule
`default_nettype wire

// ===== sv/dls_front.sv =====
// Front end: accepts items, filters unusable ones, pushes into a short queue.
`default_nettype none
module dls_front #(
  parameter int unsigned Depth = 4
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  dls_pkg::in_item_t    in_data_i,
  output logic                 q_valid_o,
  input  wire                  q_pop_i,
  output dls_pkg::in_item_t    q_data_o
);
  import dls_pkg::*;
  localparam int unsigned PtrW = $clog2(Depth);

  in_item_t       mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic            push, keep;

  // Items of unknown kind give nothing and are dropped here.
  assign keep       = (kind_e'(in_data_i.kind) != KIND_NONE);
  assign in_ready_o = (cnt_q != (PtrW+1)'(Depth));
  assign push       = in_valid_i && in_ready_o && keep;
  assign q_valid_o  = (cnt_q != '0);
  assign q_data_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == PtrW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (q_pop_i && q_valid_o) rp_q <= (rp_q == PtrW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop_i && q_valid_o);
    end
  end
endmodule
`default_nettype wire

// ===== sv/dls_back.sv =====
// Back end: stores, shared MAC, saturation, sigmoid lookup, result register.
`default_nettype none
module dls_back #(
  parameter int unsigned MaxIn  = 16,
  parameter int unsigned MaxOut = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  dls_pkg::cfg_wr_t     cfg_i,
  input  wire                  q_valid_i,
  output logic                 q_pop_o,
  input  dls_pkg::in_item_t    q_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output dls_pkg::out_item_t   out_data_o
);
  import dls_pkg::*;
  localparam int unsigned InW  = (MaxIn  > 1) ? $clog2(MaxIn)  : 1;
  localparam int unsigned OutW = (MaxOut > 1) ? $clog2(MaxOut) : 1;
  localparam int unsigned WAddrW = InW + OutW;
  localparam int unsigned WDepth = 2 ** WAddrW;
  localparam int unsigned NoMax = (MaxOut < ResultLimit) ? MaxOut : ResultLimit;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BIAS, ST_MAC, ST_DRAIN, ST_LUT, ST_OUT
  } state_e;

  // Stores
  logic [ValW-1:0] wmem [WDepth];
  logic [ValW-1:0] bmem [MaxOut];
  logic [ValW-1:0] amem [MaxIn];

  state_e          st_q;
  logic [CntW-1:0] in_cnt_q, out_cnt_q;
  logic [CntW-1:0] ni_q, no_q;
  logic [OutW-1:0] o_q;
  logic [InW-1:0]  i_q;
  logic            last_i_q;
  logic [ValW-1:0] w_rd_q, a_rd_q, b_rd_q;
  logic            mac_en_q;
  logic signed [2*ValW-1:0] prod_q;
  logic            prod_en_q;
  logic signed [AccW-1:0] acc_q;
  logic [7:0]      t_q;
  out_item_t       res_q;
  logic            res_valid_q;

  logic [CntW-1:0] ni_c, no_c;
  logic            src_ok, dst_ok, is_w, is_b, is_a, start;
  logic signed [AccW-1:0] acc_sum;
  logic signed [AccW-1:0] sh;
  logic [7:0]      t_c;
  logic [WAddrW-1:0] waddr, raddr;

  // Clamp the counts to their usable range.
  always_comb begin
    ni_c = in_cnt_q;
    if (in_cnt_q == '0) ni_c = CntW'(1);
    else if (32'(in_cnt_q) > MaxIn) ni_c = CntW'(MaxIn);
    no_c = out_cnt_q;
    if (out_cnt_q == '0) no_c = CntW'(1);
    else if (32'(out_cnt_q) > NoMax) no_c = CntW'(NoMax);
  end

  // Classify the queue head.
  assign src_ok = (32'(q_data_i.src_index) < MaxIn);
  assign dst_ok = (32'(q_data_i.dst_index) < MaxOut);
  assign is_w   = kind_e'(q_data_i.kind) == KIND_WEIGHT;
  assign is_b   = kind_e'(q_data_i.kind) == KIND_BIAS;
  assign is_a   = kind_e'(q_data_i.kind) == KIND_ACT;
  assign q_pop_o = (st_q == ST_IDLE) && q_valid_i;
  assign start   = q_pop_o && is_a && q_data_i.final_element;
  assign waddr = {OutW'(q_data_i.dst_index), InW'(q_data_i.src_index)};
  assign raddr = {o_q, i_q};

  always_ff @(posedge clk_i) begin
    if (q_pop_o && is_w && src_ok && dst_ok) wmem[waddr] <= q_data_i.value;
    if (q_pop_o && is_b && dst_ok) bmem[OutW'(q_data_i.dst_index)] <= q_data_i.value;
    if (q_pop_o && is_a && src_ok) amem[InW'(q_data_i.src_index)] <= q_data_i.value;
    w_rd_q <= wmem[raddr];
    a_rd_q <= amem[i_q];
    b_rd_q <= bmem[o_q];
  end

  // Product stage then accumulate.
  always_ff @(posedge clk_i) begin
    prod_q <= $signed(w_rd_q) * $signed(a_rd_q);
  end

  assign acc_sum = acc_q + AccW'(prod_q);
  // Saturating index: floor(acc/2^20)+128 clamped to [0,255].
  assign sh = acc_q >>> 20;
  always_comb begin
    if (sh < -$signed(AccW'(128))) t_c = 8'd0;
    else if (sh > $signed(AccW'(127))) t_c = 8'd255;
    else t_c = 8'(sh + AccW'(128));
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      in_cnt_q <= CntW'(16);
      out_cnt_q <= CntW'(16);
      ni_q <= '0; no_q <= '0; o_q <= '0; i_q <= '0;
      last_i_q <= 1'b0; mac_en_q <= 1'b0; prod_en_q <= 1'b0;
      acc_q <= '0; t_q <= '0; res_q <= '0; res_valid_q <= 1'b0;
    end else begin
      if (cfg_i.wr) begin
        if (cfg_i.cfg_in) in_cnt_q <= cfg_i.data;
        else out_cnt_q <= cfg_i.data;
      end
      // ST_OUT handles the output register itself
      if (res_valid_q && out_ready_i && st_q != ST_OUT) res_valid_q <= 1'b0;
      mac_en_q  <= (st_q == ST_MAC);
      prod_en_q <= mac_en_q;
      if (prod_en_q) acc_q <= acc_sum;
      case (st_q)
        ST_IDLE: begin
          if (start) begin
            ni_q <= ni_c; no_q <= no_c;
            o_q <= '0; i_q <= '0;
            st_q <= ST_BIAS;
          end
        end
        ST_BIAS: begin
          // bias read was issued with o_q; wait here for the registered data
          st_q <= ST_MAC;
        end
        ST_MAC: begin
          if (!mac_en_q && !prod_en_q && i_q == '0 && !last_i_q) begin
            acc_q <= AccW'($signed(b_rd_q)) <<< 12;
          end
          if (32'(i_q) + 1 == 32'(ni_q)) begin
            last_i_q <= 1'b1;
            st_q <= ST_DRAIN;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!mac_en_q && !prod_en_q) st_q <= ST_LUT;
        end
        ST_LUT: begin
          t_q <= t_c;
          st_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!res_valid_q || out_ready_i) begin
            res_valid_q <= 1'b1;
            res_q.out_index  <= IdxW'(o_q);
            res_q.activation <= SigTable[t_q];
            res_q.run_end    <= (32'(o_q) + 1 == 32'(no_q));
            last_i_q <= 1'b0;
            i_q <= '0;
            if (32'(o_q) + 1 == 32'(no_q)) begin
              o_q <= '0;
              st_q <= ST_IDLE;
            end else begin
              o_q <= o_q + 1'b1;
              st_q <= ST_BIAS;
            end
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/dls_checker.sv =====
// Port-level checker for the dense layer unit, bound to the top level.
`default_nettype none
module dls_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid,
  input wire        out_ready,
  input wire [17:0] out_data,
  input wire        cfg_ready
);
  // Held result stays stable while stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  // Activation never exceeds 1.0 in Q1.12.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data[13:1] <= 13'd4096)
    else $error("activation out of range");
  // After a result that does not end the run, the next result does not restart at index zero.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_data[0] |=> !out_valid || out_data[17:14] != 4'd0)
    else $error("index restarted mid run");
  // Configuration is always taken.
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready)
    else $error("config not ready");
endmodule

bind dense_layer_sigmoid_forward_unit dls_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_data(out_if.data), .cfg_ready(cfg_if.ready)
);
`default_nettype wire

// ===== verif/tb_dense_layer_sigmoid_forward_unit.sv =====
// Testbench for the dense layer sigmoid unit: scoreboard prediction and random traffic.
`default_nettype none
module tb_dense_layer_sigmoid_forward_unit;
  import dls_pkg::*;

  // Scoreboard: own copy of the stores, counts and sigmoid table
  class layer_scoreboard;
    logic [ValW-1:0] weights [16][16];
    logic [ValW-1:0] biases [16];
    logic [ValW-1:0] acts [16];
    logic [CntW-1:0] n_in, n_out;
    logic [ActW-1:0] sig [256];
    out_item_t pending [$];
    int errors;
    int checked;

    function new();
      logic [63:0] p, den;
      p = 64'd1073741824;
      for (int k = 0; k <= 128; k++) begin
        den = 64'd1073741824 + p;
        if (k < 128) sig[128 + k] = ActW'(((64'd4096 << 30) + den / 2) / den);
        if (k >= 1) sig[128 - k] = ActW'((64'd4096 * p + den / 2) / den);
        p = (p * 64'd1008687091 + (64'd1 << 29)) >> 30;
      end
      n_in = 16;
      n_out = 16;
      errors = 0;
      checked = 0;
    endfunction

    function void set_count(logic idx, logic [CntW-1:0] v);
      if (idx == CFG_IN_COUNT) n_in = v;
      else n_out = v;
    endfunction

    function int unsigned clamp16(logic [CntW-1:0] v);
      if (v == 0) return 1;
      if (v > 16) return 16;
      return v;
    endfunction

    // Note an accepted input; a final activation queues one result per neuron
    function void note_input(in_item_t it);
      longint acc, t;
      int unsigned ni, no;
      out_item_t r;
      case (kind_e'(it.kind))
        KIND_WEIGHT: weights[it.dst_index][it.src_index] = it.value;
        KIND_BIAS:   biases[it.dst_index] = it.value;
        KIND_ACT: begin
          acts[it.src_index] = it.value;
          if (it.final_element) begin
            ni = clamp16(n_in);
            no = clamp16(n_out);
            for (int o = 0; o < no; o++) begin
              acc = longint'($signed(biases[o])) * 4096;
              for (int i = 0; i < ni; i++)
                acc += longint'($signed(weights[o][i])) * longint'($signed(acts[i]));
              t = (acc >>> 20) + 128;
              if (t < 0) t = 0;
              if (t > 255) t = 255;
              r.out_index = o[IdxW-1:0];
              r.activation = sig[t];
              r.run_end = (o + 1 == no);
              pending.push_back(r);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result idx=%0d act=%0d end=%0b", $time,
                 got.out_index, got.activation, got.run_end);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.out_index !== exp_r.out_index) begin
        $display("%0t: out_index expected %0d actual %0d", $time, exp_r.out_index,
                 got.out_index);
        errors++;
      end
      if (got.activation !== exp_r.activation) begin
        $display("%0t: activation expected %0d actual %0d", $time, exp_r.activation,
                 got.activation);
        errors++;
      end
      if (got.run_end !== exp_r.run_end) begin
        $display("%0t: run_end expected %0b actual %0b", $time, exp_r.run_end,
                 got.run_end);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  dls_stream_if #(.T(in_item_t))  in_if ();
  dls_stream_if #(.T(out_item_t)) out_if ();
  dls_cfg_if cfg_if ();

  dense_layer_sigmoid_forward_unit DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if.sink),
    .out_if(out_if.source),
    .cfg_if(cfg_if.sink)
  );

  layer_scoreboard sb = new();
  int n_items = 0;
  int n_runs = 0;
  logic stall_free = 1'b0;

  // Result side: random ready, check every transaction
  initial begin
    int gap;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
      if (out_if.ready && !(out_if.valid)) ;
      if (out_if.valid && out_if.ready || !out_if.ready) begin
        gap = stall_free ? 0 : $urandom_range(0, 7);
        if (gap > 0 && out_if.ready) begin
          out_if.ready <= 1'b0;
          repeat (gap - 1) begin
            @(posedge clk_i);
          end
          @(posedge clk_i);
        end
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    gap = stall_free ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(it);
    n_items++;
    if (it.kind == KIND_ACT && it.final_element) n_runs++;
  endtask

  task automatic make_item(kind_e k, int s, int d, logic [ValW-1:0] v, logic f);
    in_item_t it;
    it.kind = k;
    it.src_index = s[IdxW-1:0];
    it.dst_index = d[IdxW-1:0];
    it.value = v;
    it.final_element = f;
    send_item(it);
  endtask

  // Drain all expected results, then let the back end settle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CntW-1:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.set_count(idx, v);
  endtask

  // Fill the first rows of the weight and bias stores and every activation
  task automatic load_all(bit extreme, int rows);
    logic [ValW-1:0] v;
    for (int o = 0; o < rows; o++) begin
      v = extreme ? (($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000) : 16'($urandom);
      make_item(KIND_BIAS, $urandom_range(0, 15), o, v, $urandom_range(0, 1));
      for (int i = 0; i < 16; i++) begin
        v = extreme ? (($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000)
                    : 16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 2047) - 1024);
        make_item(KIND_WEIGHT, i, o, v, $urandom_range(0, 1));
      end
    end
    for (int i = 0; i < 16; i++)
      make_item(KIND_ACT, i, $urandom_range(0, 15), 16'($urandom), 1'b0);
  endtask

  task automatic random_phase(int count, int n_in_sel, int n_out_sel);
    int r;
    write_reg(CFG_IN_COUNT, CntW'(n_in_sel));
    write_reg(CFG_OUT_COUNT, CntW'(n_out_sel));
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 10)
        make_item(KIND_WEIGHT, $urandom_range(0, 15), $urandom_range(0, 15),
                  16'($urandom), $urandom_range(0, 1));
      else if (r < 15)
        make_item(KIND_BIAS, $urandom_range(0, 15), $urandom_range(0, 15),
                  16'($urandom), $urandom_range(0, 1));
      else if (r < 20)
        make_item(KIND_NONE, $urandom_range(0, 15), $urandom_range(0, 15),
                  16'($urandom), $urandom_range(0, 1));
      else
        make_item(KIND_ACT, $urandom_range(0, 15), $urandom_range(0, 15),
                  16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 1023) - 512),
                  $urandom_range(0, 5) == 0);
    end
    wait_idle();
  endtask

  // Stimulus
  initial begin
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_IN_COUNT;
    cfg_if.wdata <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: full load, saturated rows, both count extremes, out-of-range counts
    stall_free = 1'b1;
    load_all(1'b0, 16);
    wait_idle();
    write_reg(CFG_OUT_COUNT, 5'd2);
    load_all(1'b1, 2);
    make_item(KIND_ACT, 15, 0, 16'h7FFF, 1'b1);
    make_item(KIND_ACT, 0, 15, 16'h8000, 1'b1);
    make_item(KIND_NONE, 3, 3, 16'hFFFF, 1'b1);
    wait_idle();
    write_reg(CFG_IN_COUNT, 5'd1);
    write_reg(CFG_OUT_COUNT, 5'd1);
    make_item(KIND_ACT, 0, 0, 16'h0000, 1'b1);
    wait_idle();
    write_reg(CFG_IN_COUNT, 5'd0);
    write_reg(CFG_OUT_COUNT, 5'd31);
    make_item(KIND_ACT, 1, 0, 16'h1000, 1'b1);
    wait_idle();
    stall_free = 1'b0;

    // Random phases with varied counts
    random_phase(30, 16, 16);
    random_phase(25, $urandom_range(1, 16), $urandom_range(1, 16));
    stall_free = 1'b1;
    random_phase(20, 3, 5);
    stall_free = 1'b0;
    random_phase(30, $urandom_range(0, 31), $urandom_range(0, 31));
    random_phase(20, 1, 16);

    repeat (50) @(posedge clk_i);
    $display("Covered %0d input items and %0d runs, %0d results checked.",
             n_items, n_runs, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout");
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
